// ===== src/sfo_pkg.sv =====
`default_nettype none

package sfo_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    FUNC_SUB       = 2'd0,
    FUNC_UNSUB     = 2'd1,
    FUNC_UNSUB_ALL = 2'd2,
    FUNC_NOTIFY    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    func_t              func;
    logic [15:0]        subscriber;
    logic signed [31:0] object_key;
    logic [15:0]        property_key;
    logic [7:0]         dest_handle;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  dest_port;
    logic        last;
    count_t      key_count;
    count_t      total_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] object_key;
    logic [15:0] property_key;
    logic [15:0] subscriber;
    logic [7:0]  port;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_COLLAPSE,
    CELL_LOAD
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       sel;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/sfo_cell.sv =====
`default_nettype none

module sfo_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sfo_pkg::cell_ctrl_t ctrl,
  input  wire logic                left_valid,
  input  wire logic                right_valid,
  input  wire sfo_pkg::entry_t     right_entry,
  input  wire sfo_pkg::entry_t     new_entry,
  output logic                     valid,
  output sfo_pkg::entry_t          entry
);

  // In collapse mode an empty cell pulls from its right-hand neighbour, and a
  // full cell whose left-hand neighbour is empty hands its entry over, so gaps
  // drift to the tail one place per cycle and the order is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.mode)
        sfo_pkg::CELL_SHIFT: begin
          valid <= right_valid;
        end
        sfo_pkg::CELL_COLLAPSE: begin
          if (!valid) begin
            valid <= right_valid;
          end else if (!left_valid) begin
            valid <= 1'b0;
          end
        end
        sfo_pkg::CELL_LOAD: begin
          if (ctrl.sel) begin
            valid <= 1'b1;
          end
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      sfo_pkg::CELL_SHIFT: begin
        entry <= right_entry;
      end
      sfo_pkg::CELL_COLLAPSE: begin
        if (!valid && right_valid) begin
          entry <= right_entry;
        end
      end
      sfo_pkg::CELL_LOAD: begin
        if (ctrl.sel) begin
          entry <= new_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/subscription_fanout_table.sv =====
// Sequence: every command first scans the whole cell chain (S_COUNT); a single result is then
// loaded in S_FINISH. Notify with matches then rotates the chain again (S_EMIT), giving one
// result per match in chain order. Removals then run a gap-closing pass (S_COLLAPSE). A new
// command is taken only in S_IDLE; a result that is not taken pauses S_FINISH and S_EMIT.
// Reset: rst clears every valid bit, the fill count and the handshakes; entry data is kept.
`default_nettype none

module subscription_fanout_table #(
  parameter int TABLE_ENTRIES = sfo_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire sfo_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output sfo_pkg::rsp_t      rsp
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_FINISH,
    S_EMIT,
    S_COLLAPSE
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     cnt;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     key_cnt;
  logic [CNT_W-1:0]     tot_cnt;
  logic [CNT_W-1:0]     emit_cnt;
  logic                 dup;
  sfo_pkg::cmd_t        item;

  logic                 cell_valid [TABLE_ENTRIES];
  sfo_pkg::entry_t      cell_entry [TABLE_ENTRIES];
  sfo_pkg::entry_t      new_entry;
  sfo_pkg::cell_mode_t  mode;
  logic                 ring_valid;

  logic head_valid;
  logic key_eq;
  logic sub_eq;
  logic key_hit;
  logic drop;
  logic out_free;
  logic pass_end;
  logic full;
  logic do_write;
  logic rsp_set;

  assign head_valid = cell_valid[0];
  assign key_eq     = (cell_entry[0].object_key == item.object_key)
                   && (cell_entry[0].property_key == item.property_key);
  assign sub_eq     = cell_entry[0].subscriber == item.subscriber;
  assign key_hit    = head_valid && key_eq;
  assign drop       = head_valid && sub_eq
                   && ((item.func == sfo_pkg::FUNC_UNSUB && key_eq)
                    || item.func == sfo_pkg::FUNC_UNSUB_ALL);
  assign out_free   = !rsp_valid || rsp_ready;
  assign pass_end   = cnt == IDX_W'(TABLE_ENTRIES - 1);
  assign full       = fill == CNT_W'(TABLE_ENTRIES);
  assign do_write   = (state == S_FINISH) && (item.func == sfo_pkg::FUNC_SUB)
                   && !dup && !full && out_free;
  assign cmd_ready  = state == S_IDLE;
  // A new result is loaded in this cycle.
  assign rsp_set    = out_free
                   && (((state == S_FINISH)
                        && ((item.func != sfo_pkg::FUNC_NOTIFY) || (key_cnt == '0)))
                    || ((state == S_EMIT) && key_hit));

  assign new_entry.object_key   = item.object_key;
  assign new_entry.property_key = item.property_key;
  assign new_entry.subscriber   = item.subscriber;
  assign new_entry.port         = item.dest_handle;

  // The head of the chain is re-entered at the tail; a removed entry re-enters
  // as an empty cell, which the collapse pass later moves to the end.
  always_comb begin
    mode       = sfo_pkg::CELL_HOLD;
    ring_valid = 1'b0;
    case (state)
      S_COUNT: begin
        mode       = sfo_pkg::CELL_SHIFT;
        ring_valid = head_valid && !drop;
      end
      S_EMIT: begin
        mode       = out_free ? sfo_pkg::CELL_SHIFT : sfo_pkg::CELL_HOLD;
        ring_valid = head_valid;
      end
      S_COLLAPSE: begin
        mode = sfo_pkg::CELL_COLLAPSE;
      end
      S_FINISH: begin
        mode = do_write ? sfo_pkg::CELL_LOAD : sfo_pkg::CELL_HOLD;
      end
      default: begin
        mode = sfo_pkg::CELL_HOLD;
      end
    endcase
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    localparam logic [CNT_W-1:0] POS = CNT_W'(i);
    sfo_pkg::cell_ctrl_t ctrl;
    logic                left_v;
    logic                right_v;
    sfo_pkg::entry_t     right_e;

    assign ctrl.mode = mode;
    assign ctrl.sel  = fill == POS;

    if (i == 0) begin : g_first
      assign left_v = 1'b1;
    end else begin : g_rest
      assign left_v = cell_valid[i-1];
    end

    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign right_v = ring_valid;
      assign right_e = cell_entry[0];
    end else begin : g_body
      assign right_v = cell_valid[i+1];
      assign right_e = cell_entry[i+1];
    end

    sfo_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_valid  (left_v),
      .right_valid (right_v),
      .right_entry (right_e),
      .new_entry   (new_entry),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready && !rsp_set) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item    <= cmd;
            cnt     <= '0;
            key_cnt <= '0;
            tot_cnt <= '0;
            dup     <= 1'b0;
            state   <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (key_hit && !drop) begin
            key_cnt <= key_cnt + CNT_W'(1);
          end
          if (head_valid && !drop) begin
            tot_cnt <= tot_cnt + CNT_W'(1);
          end
          if (key_hit && sub_eq) begin
            dup <= 1'b1;
          end
          if (pass_end) begin
            cnt   <= '0;
            state <= S_FINISH;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_FINISH: begin
          case (item.func)
            sfo_pkg::FUNC_SUB: begin
              if (out_free) begin
                rsp_valid     <= 1'b1;
                rsp.dest_port <= '0;
                rsp.last      <= 1'b1;
                if (dup) begin
                  rsp.status      <= sfo_pkg::ST_DUP;
                  rsp.key_count   <= sfo_pkg::count_t'(key_cnt);
                  rsp.total_count <= sfo_pkg::count_t'(fill);
                end else if (full) begin
                  rsp.status      <= sfo_pkg::ST_FULL;
                  rsp.key_count   <= sfo_pkg::count_t'(key_cnt);
                  rsp.total_count <= sfo_pkg::count_t'(fill);
                end else begin
                  rsp.status      <= sfo_pkg::ST_OK;
                  rsp.key_count   <= sfo_pkg::count_t'(key_cnt + CNT_W'(1));
                  rsp.total_count <= sfo_pkg::count_t'(fill + CNT_W'(1));
                  fill            <= fill + CNT_W'(1);
                end
                state <= S_IDLE;
              end
            end
            sfo_pkg::FUNC_UNSUB, sfo_pkg::FUNC_UNSUB_ALL: begin
              if (out_free) begin
                rsp_valid       <= 1'b1;
                rsp.status      <= sfo_pkg::ST_OK;
                rsp.dest_port   <= '0;
                rsp.last        <= 1'b1;
                rsp.key_count   <= sfo_pkg::count_t'(key_cnt);
                rsp.total_count <= sfo_pkg::count_t'(tot_cnt);
                fill            <= tot_cnt;
                cnt             <= '0;
                state           <= S_COLLAPSE;
              end
            end
            default: begin
              if (key_cnt == '0) begin
                if (out_free) begin
                  rsp_valid       <= 1'b1;
                  rsp.status      <= sfo_pkg::ST_NOT_FOUND;
                  rsp.dest_port   <= '0;
                  rsp.last        <= 1'b1;
                  rsp.key_count   <= '0;
                  rsp.total_count <= sfo_pkg::count_t'(fill);
                  state           <= S_IDLE;
                end
              end else begin
                emit_cnt <= '0;
                cnt      <= '0;
                state    <= S_EMIT;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            cnt <= cnt + IDX_W'(1);
            if (key_hit) begin
              rsp_valid       <= 1'b1;
              rsp.status      <= sfo_pkg::ST_OK;
              rsp.dest_port   <= cell_entry[0].port;
              rsp.last        <= (emit_cnt + CNT_W'(1)) == key_cnt;
              rsp.key_count   <= sfo_pkg::count_t'(key_cnt);
              rsp.total_count <= sfo_pkg::count_t'(fill);
              emit_cnt        <= emit_cnt + CNT_W'(1);
            end
            if (pass_end) begin
              state <= S_IDLE;
            end
          end
        end
        S_COLLAPSE: begin
          cnt <= cnt + IDX_W'(1);
          if (pass_end) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/sfo_checker.sv =====
`default_nettype none

module sfo_checker #(
  parameter int TABLE_ENTRIES = sfo_pkg::TABLE_ENTRIES_DEF
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          cmd_valid,
  input wire logic          cmd_ready,
  input wire sfo_pkg::cmd_t cmd,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire sfo_pkg::rsp_t rsp
);

  // A result that is not taken stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed or dropped while stalled");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.total_count <= TABLE_ENTRIES && rsp.key_count <= rsp.total_count)
    else $error("key or total count out of range");

  // Non-ok answers are single results with no port; only notify matches carry a port.
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != sfo_pkg::ST_OK |-> rsp.last && rsp.dest_port == '0)
    else $error("non-ok result is not a lone result");

  // A command that is offered but not taken is held unchanged.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command changed or withdrawn before its transfer");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == sfo_pkg::ST_FULL |-> rsp.total_count == TABLE_ENTRIES)
    else $error("table-full result with free entries");

endmodule

bind subscription_fanout_table sfo_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_sfo_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
